[hw/rtl/tsg_pkg.sv]
// Shared types and constants for the Taylor-series sine generator.
// No dependencies; imported by the controller, datapath and top level.
package tsg_pkg;

    localparam int PhaseW = 32;
    localparam int SampleW = 10;
    localparam int DacW = 16;
    localparam int OpW = 33;
    localparam int ProdW = 2 * OpW;

    localparam logic [PhaseW-1:0] PhaseStepReset = 32'd4294967;

    localparam logic signed [OpW-1:0] PiQ28 = 33'sd843314856;
    localparam logic signed [OpW-1:0] OneQ30 = 33'sd1073741824;
    localparam logic signed [OpW-1:0] C3Q30 = -33'sd178956971;
    localparam logic signed [OpW-1:0] C5Q30 = 33'sd8947849;
    localparam logic signed [OpW-1:0] C7Q30 = -33'sd213044;
    localparam logic signed [OpW-1:0] C9Q30 = 33'sd2959;
    localparam logic signed [OpW-1:0] C11Q30 = -33'sd27;

    localparam logic [3:0] FrameTop = 4'hF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        STEP_ANGLE,
        STEP_SQUARE,
        STEP_H9,
        STEP_H7,
        STEP_H5,
        STEP_H3,
        STEP_H1,
        STEP_SINE
    } step_t;

    typedef struct packed {
        logic  start;
        logic  mul_en;
        logic  wb_en;
        logic  out_load;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

    function automatic logic signed [OpW-1:0] horner_coef(step_t s);
        logic signed [OpW-1:0] c;
        unique case (s)
            STEP_H9: c = C9Q30;
            STEP_H7: c = C7Q30;
            STEP_H5: c = C5Q30;
            STEP_H3: c = C3Q30;
            STEP_H1: c = OneQ30;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/taylor_sine_wave_generator.sv]
// Top level of the Taylor-series sine generator: controller plus datapath.
// Depends on tsg_pkg, tsg_ctrl, tsg_dp.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_restart
//   m_       out        m_valid / m_ready    m_sample, m_dac_word
//   cfg_     in         cfg_valid/cfg_ready  cfg_data (phase_step)
//
// m_valid rises after the beat passes through eight products on the single
// shared multiplier, each a multiply step and a writeback step, and then the
// load of the output register. s_ready is high only while the sequencer is
// idle, so no new beat is taken before the previous one is loaded; the load
// waits while an earlier result is still held with m_ready low, and the next
// beat is taken while a loaded result is held.
// Synchronous active-low reset: phase 0, phase_step 4294967, no result held.
module taylor_sine_wave_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tsg_pkg::SampleW-1:0]   m_sample,
    output logic [tsg_pkg::DacW-1:0]      m_dac_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsg_pkg::PhaseW-1:0]    cfg_data
);
    import tsg_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    tsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsg_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_restart (s_restart),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sample  (m_sample)
    );

    assign cfg_ready  = 1'b1;
    assign m_dac_word = {FrameTop, m_sample, 2'b00};

endmodule

[hw/rtl/tsg_ctrl.sv]
// Sequencer for the sine generator: accepts a beat, walks the eight
// multiply/writeback steps, then hands the result to the output register.
// Depends on tsg_pkg.
module tsg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tsg_pkg::dp_sts_t sts,
    output tsg_pkg::dp_cmd_t cmd
);
    import tsg_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_ANGLE;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                    step_next  = STEP_ANGLE;
                end
            end
            ST_MUL: state_next = ST_WB;
            ST_WB: begin
                if (step_reg == STEP_SINE) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_MUL;
                    step_next  = step_t'(step_reg + 3'd1);
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.step     = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_MUL:  cmd.mul_en = 1'b1;
            ST_WB:   cmd.wb_en = 1'b1;
            ST_FIN:  cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[hw/rtl/tsg_dp.sv]
// Datapath for the sine generator: phase accumulator, one shared 33x33
// multiplier with registered product, Horner registers and output register.
// Depends on tsg_pkg.
module tsg_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsg_pkg::dp_cmd_t              cmd,
    output tsg_pkg::dp_sts_t              sts,
    input  logic                          s_restart,
    input  logic                          cfg_valid,
    input  logic [tsg_pkg::PhaseW-1:0]    cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tsg_pkg::SampleW-1:0]   m_sample
);
    import tsg_pkg::*;

    logic [PhaseW-1:0]         phase_reg, step_reg, work_reg;
    logic signed [OpW-1:0]     t_reg, u_reg, p_reg;
    logic signed [33:0]        s_reg;
    logic signed [ProdW-1:0]   prod_reg;
    logic                      valid_reg;
    logic [SampleW-1:0]        sample_reg;

    logic [PhaseW-1:0]         work_next;
    logic signed [OpW-1:0]     op_a, op_b, coef;
    logic signed [ProdW-1:0]   prod_next;
    logic signed [33:0]        prod_q28;
    logic signed [33:0]        p_sum;
    logic signed [34:0]        x_w;
    logic signed [44:0]        y_w;
    logic signed [13:0]        v_w;
    logic [SampleW-1:0]        sample_next;

    assign work_next = s_restart ? '0 : phase_reg;

    always_comb begin
        unique case (cmd.step)
            STEP_ANGLE: begin
                op_a = {~work_reg[31], ~work_reg[31], work_reg[30:0]};
                op_b = PiQ28;
            end
            STEP_SQUARE: begin
                op_a = t_reg;
                op_b = t_reg;
            end
            STEP_SINE: begin
                op_a = p_reg;
                op_b = t_reg;
            end
            default: begin
                op_a = p_reg;
                op_b = u_reg;
            end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign prod_q28  = prod_reg[61:28];
    assign coef      = horner_coef(cmd.step);
    assign p_sum     = prod_q28 + {coef[OpW-1], coef};

    // sample = floor(1023 * (2^30 - s) / 2^31), clamped
    assign x_w = 35'sd1073741824 - {s_reg[33], s_reg};
    assign y_w = {x_w, 10'b0} - {{10{x_w[34]}}, x_w};
    assign v_w = y_w[44:31];

    always_comb begin
        if (v_w[13]) begin
            sample_next = '0;
        end else if (v_w[12:10] != 3'd0) begin
            sample_next = '1;
        end else begin
            sample_next = v_w[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            step_reg  <= PhaseStepReset;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                step_reg <= cfg_data;
            end
            if (cmd.start) begin
                phase_reg <= work_next + step_reg;
            end
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            work_reg <= work_next;
            p_reg    <= C11Q30;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.wb_en) begin
            unique case (cmd.step)
                STEP_ANGLE:  t_reg <= prod_reg[63:31];
                STEP_SQUARE: u_reg <= prod_reg[60:28];
                STEP_SINE:   s_reg <= prod_q28;
                default:     p_reg <= p_sum[OpW-1:0];
            endcase
        end
        if (cmd.out_load) begin
            sample_reg <= sample_next;
        end
    end

    assign sts.out_free = !valid_reg || m_ready;
    assign m_valid      = valid_reg;
    assign m_sample     = sample_reg;

endmodule

[hw/rtl/tsg_checker.sv]
// Port-level checks for the sine generator, bound to the top level.
// Depends on tsg_pkg and taylor_sine_wave_generator.
module tsg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_restart,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tsg_pkg::SampleW-1:0]   m_sample,
    input logic [tsg_pkg::DacW-1:0]      m_dac_word,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [tsg_pkg::PhaseW-1:0]    cfg_data
);
    import tsg_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample))
        else $error("result beat dropped or changed while stalled");

    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dac_word[15:12] == FrameTop && m_dac_word[11:2] == m_sample
                    && m_dac_word[1:0] == 2'b00)
        else $error("DAC frame does not match sample");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in work");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared right after acceptance");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result delivered while sequencer still busy");

endmodule

bind taylor_sine_wave_generator tsg_checker u_tsg_checker (.*);

[dv/sine_checker.sv]
// Scoreboard for the sine generator: tracks phase and phase_step from the input
// and config beats, predicts each sample, and checks result beats in order.
// Depends on tsg_pkg for signal widths only.
module sine_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_restart,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [tsg_pkg::SampleW-1:0] m_sample,
    input  logic [tsg_pkg::DacW-1:0]    m_dac_word,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [tsg_pkg::PhaseW-1:0]  cfg_data,
    output int                          errors,
    output int                          outstanding
);
    import tsg_pkg::*;

    localparam logic [31:0] StepAtReset = 32'd4294967;
    localparam longint PiFix = 64'sd843314856;
    localparam longint UnitFix = 64'sd1073741824;
    localparam longint K3 = -64'sd178956971;
    localparam longint K5 = 64'sd8947849;
    localparam longint K7 = -64'sd213044;
    localparam longint K9 = 64'sd2959;
    localparam longint K11 = -64'sd27;

    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic [DacW-1:0]    dac;
    } sine_beat_t;

    logic [31:0] phase;
    logic [31:0] step;
    sine_beat_t  due[$];

    // >>> on signed longint floors, which is what the fixed-point math wants
    function automatic logic [SampleW-1:0] sine_code(input logic [31:0] ph);
        longint d, t, u, p, v;
        d = $signed({32'd0, ph}) - (64'sd1 <<< 31);
        t = (d * PiFix) >>> 31;
        u = (t * t) >>> 28;
        p = K11;
        p = ((p * u) >>> 28) + K9;
        p = ((p * u) >>> 28) + K7;
        p = ((p * u) >>> 28) + K5;
        p = ((p * u) >>> 28) + K3;
        p = ((p * u) >>> 28) + UnitFix;
        v = -((p * t) >>> 28);
        v = (64'sd1023 * (UnitFix + v)) >>> 31;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[SampleW-1:0];
    endfunction

    always @(posedge aclk) begin
        sine_beat_t got;
        sine_beat_t want;
        if (!aresetn) begin
            phase = '0;
            step = StepAtReset;
            due.delete();
            errors = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.sample = m_sample;
                got.dac = m_dac_word;
                if (due.size() == 0) begin
                    if (errors < 10)
                        $display("sine_checker: result beat with none due: sample %0d dac %h",
                                 got.sample, got.dac);
                    errors++;
                end else begin
                    want = due.pop_front();
                    if (got.sample !== want.sample || got.dac !== want.dac) begin
                        if (errors < 10)
                            $display({"sine_checker: expected sample %0d dac %h, ",
                                      "got sample %0d dac %h"},
                                     want.sample, want.dac, got.sample, got.dac);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_restart)
                    phase = '0;
                want.sample = sine_code(phase);
                want.dac = {4'hF, want.sample, 2'b00};
                due.push_back(want);
                phase = phase + step;
            end
            if (cfg_valid && cfg_ready)
                step = cfg_data;
            outstanding <= due.size();
        end
    end

endmodule

[dv/testbench.sv]
// Top of the sine generator testbench: clock, reset, stimulus and verdict.
// Depends on tsg_pkg, taylor_sine_wave_generator and sine_checker.
module testbench;
    import tsg_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int RandomBeats = 1700;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [SampleW-1:0] m_sample;
    logic [DacW-1:0]    m_dac_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [PhaseW-1:0]  cfg_data = '0;
    logic               calm = 1'b0;
    int                 errors;
    int                 outstanding;
    int                 cycles = 0;

    taylor_sine_wave_generator dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_restart  (s_restart),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sample   (m_sample),
        .m_dac_word (m_dac_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    sine_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample),
        .m_dac_word  (m_dac_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    task automatic send_beat(input logic restart);
        if (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            s_restart <= 1'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_step(input logic [PhaseW-1:0] step);
        cfg_valid <= 1'b1;
        cfg_data <= step;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed(input logic [PhaseW-1:0] step, input logic [4:0] restarts,
                                input int n);
        write_step(step);
        for (int i = 0; i < n; i++)
            send_beat(restarts[i]);
        drain();
    endtask

    function automatic logic [PhaseW-1:0] pick_step();
        logic [PhaseW-1:0] quarter;
        quarter = {2'($urandom_range(0, 3)), 30'd0};
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(1, 65536);
            2: return quarter + $urandom_range(0, 64) - 32;
            3: return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF;
            default: return 32'd4294967 * $urandom_range(1, 1000);
        endcase
    endfunction

    initial begin
        int sent;
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset step and phase first, then the step extremes
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
        drain();
        run_directed(32'd1, 5'b00001, 3);
        run_directed(32'hFFFF_FFFF, 5'b00001, 3);
        run_directed(32'h4000_0000, 5'b00001, 5);
        run_directed(32'h0, 5'b00100, 3);
        run_directed(32'h8000_0000, 5'b00001, 3);

        sent = 0;
        while (sent < RandomBeats) begin
            n = $urandom_range(100, 300);
            if (n > RandomBeats - sent)
                n = RandomBeats - sent;
            write_step(pick_step());
            for (int i = 0; i < n; i++) begin
                calm <= (sent + i >= 700) && (sent + i < 1000);
                send_beat($urandom_range(0, 99) < 4);
            end
            sent += n;
            drain();
        end
        calm <= 1'b0;

        repeat (30) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
